@@ design/pidc_pkg.sv @@
// ----------------------------------------------------------------------------
// pidc_pkg
// Shared types, register codes, widths and reset values for the clamped PID
// controller core and its divider.
// ----------------------------------------------------------------------------
package pidc_pkg;

  // Default sample width
  localparam int DATA_WIDTH_DEF = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Register field widths
  localparam int PERIOD_W = 15;  // sample period and integral limit
  localparam int COEF_W   = 16;  // gains and output bounds
  localparam int ACC_W    = 16;  // integral accumulator

  // Operand A of the shared multiplier: a gain, or the period zero-extended
  localparam int MUL_A_W = COEF_W + 1;

  // Register reset values
  localparam logic [PERIOD_W-1:0]      PERIOD_RST = PERIOD_W'(1);
  localparam logic [PERIOD_W-1:0]      LIMIT_RST  = PERIOD_W'(32767);
  localparam logic signed [COEF_W-1:0] OUT_MAX_RST = COEF_W'(32767);
  localparam logic signed [COEF_W-1:0] OUT_MIN_RST = -COEF_W'(32768);

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLE_PERIOD  = 3'd0,
    REG_OUTPUT_MAX     = 3'd1,
    REG_OUTPUT_MIN     = 3'd2,
    REG_GAIN_P         = 3'd3,
    REG_GAIN_I         = 3'd4,
    REG_GAIN_D         = 3'd5,
    REG_INTEGRAL_LIMIT = 3'd6
  } cfg_reg_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_I,
    S_INTEG,
    S_ADD_P,
    S_ADD_I,
    S_WAIT_DIV,
    S_MUL_D,
    S_ADD_D,
    S_CLAMP
  } state_t;

endpackage

@@ design/pid_controller_clamped_core.sv @@
// ----------------------------------------------------------------------------
// pid_controller_clamped_core
// One transaction in flight at a time. Throughput is set by the bit-serial
// divider (DATA_WIDTH + 2 steps), the shared multiplier and output back-pressure.
// Reset: synchronous; registers return to their defaults, the integral
// accumulator and previous error clear to zero.
// ----------------------------------------------------------------------------
// Discrete PID controller with a clamped integral and clamped output. One
// multiplier is shared by the integral step and the three gain products
// under a small sequencer; the derivative uses an iterative divider.
// ----------------------------------------------------------------------------
module pid_controller_clamped_core
  import pidc_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // configuration
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  // input channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [DATA_WIDTH-1:0] target,
  input  logic signed [DATA_WIDTH-1:0] measured,
  // output channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] drive
);

  localparam int ERR_W   = DATA_WIDTH + 1;
  localparam int DIFF_W  = DATA_WIDTH + 2;
  localparam int MUL_B_W = (DIFF_W > ACC_W) ? DIFF_W : ACC_W;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int INTEG_W = PROD_W + 1;
  localparam int SUM_W   = PROD_W + 2;

  // Configuration registers
  logic        [PERIOD_W-1:0] sample_period;
  logic signed [COEF_W-1:0]   output_max;
  logic signed [COEF_W-1:0]   output_min;
  logic signed [COEF_W-1:0]   gain_p;
  logic signed [COEF_W-1:0]   gain_i;
  logic signed [COEF_W-1:0]   gain_d;
  logic        [PERIOD_W-1:0] integral_limit;

  // Controller state and working registers
  state_t                    state, state_next;
  logic signed [ERR_W-1:0]   last_error;
  logic signed [ACC_W-1:0]   accumulated;
  logic signed [ERR_W-1:0]   err;
  logic signed [DIFF_W-1:0]  diff;
  logic                      deriv_neg;
  logic signed [PROD_W-1:0]  prod;
  logic signed [SUM_W-1:0]   sum;

  // Combinational signals
  logic                      accept;
  logic                      div_start;
  logic                      load_drive;
  logic signed [ERR_W-1:0]   err_next;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [DIFF_W-1:0]  deriv;
  logic        [DIFF_W-1:0]  div_dividend;
  logic        [DIFF_W-1:0]  div_quotient;
  logic        [PERIOD_W-1:0] div_divisor;
  logic                      div_busy;
  logic signed [INTEG_W-1:0] integ;
  logic signed [INTEG_W-1:0] lim_pos;
  logic signed [INTEG_W-1:0] lim_neg;
  logic signed [SUM_W-1:0]   omax;
  logic signed [SUM_W-1:0]   omin;
  logic signed [SUM_W-1:0]   clamped;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_period  <= PERIOD_RST;
      output_max     <= OUT_MAX_RST;
      output_min     <= OUT_MIN_RST;
      gain_p         <= '0;
      gain_i         <= '0;
      gain_d         <= '0;
      integral_limit <= LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SAMPLE_PERIOD:  sample_period  <= cfg_data[PERIOD_W-1:0];
        REG_OUTPUT_MAX:     output_max     <= signed'(cfg_data);
        REG_OUTPUT_MIN:     output_min     <= signed'(cfg_data);
        REG_GAIN_P:         gain_p         <= signed'(cfg_data);
        REG_GAIN_I:         gain_i         <= signed'(cfg_data);
        REG_GAIN_D:         gain_d         <= signed'(cfg_data);
        REG_INTEGRAL_LIMIT: integral_limit <= cfg_data[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: next state and strobes
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    div_start  = 1'b0;
    load_drive = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = S_MUL_I;
      end
      S_MUL_I: state_next = S_INTEG;
      S_INTEG: begin
        div_start  = 1'b1;
        state_next = S_ADD_P;
      end
      S_ADD_P: state_next = S_ADD_I;
      S_ADD_I: state_next = S_WAIT_DIV;
      S_WAIT_DIV: begin
        if (!div_busy) state_next = S_MUL_D;
      end
      S_MUL_D: state_next = S_ADD_D;
      S_ADD_D: state_next = S_CLAMP;
      S_CLAMP: begin
        if (!out_valid || out_ready) begin
          load_drive = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign accept   = in_valid && in_ready;
  assign err_next = ERR_W'(target) - ERR_W'(measured);

  // Derivative divider: magnitude of the error step over the period
  assign div_dividend = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
  assign div_divisor  = (sample_period == '0) ? PERIOD_W'(1) : sample_period;
  assign deriv        = deriv_neg ? -signed'(div_quotient) : signed'(div_quotient);

  pidc_divider #(
    .DIVIDEND_W (DIFF_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quotient),
    .busy     (div_busy)
  );

  // Shared multiplier operand selection
  always_comb begin
    case (state)
      S_MUL_I: begin
        mul_a = MUL_A_W'(signed'({1'b0, sample_period}));
        mul_b = MUL_B_W'(err);
      end
      S_INTEG: begin
        mul_a = MUL_A_W'(gain_p);
        mul_b = MUL_B_W'(err);
      end
      S_ADD_P: begin
        mul_a = MUL_A_W'(gain_i);
        mul_b = MUL_B_W'(accumulated);
      end
      default: begin
        mul_a = MUL_A_W'(gain_d);
        mul_b = MUL_B_W'(deriv);
      end
    endcase
  end

  // Integral update with symmetric clamp
  always_comb begin
    integ   = INTEG_W'(accumulated) + INTEG_W'(prod);
    lim_pos = INTEG_W'(signed'({1'b0, integral_limit}));
    lim_neg = -lim_pos;
  end

  // Output clamp: upper bound tested first
  always_comb begin
    omax = SUM_W'(output_max);
    omin = SUM_W'(output_min);
    if (sum > omax) begin
      clamped = omax;
    end else if (sum < omin) begin
      clamped = omin;
    end else begin
      clamped = sum;
    end
  end

  // Controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      last_error  <= '0;
      accumulated <= '0;
    end else begin
      if (accept) last_error <= err_next;
      if (state == S_INTEG) begin
        if (integ > lim_pos) begin
          accumulated <= lim_pos[ACC_W-1:0];
        end else if (integ < lim_neg) begin
          accumulated <= lim_neg[ACC_W-1:0];
        end else begin
          accumulated <= integ[ACC_W-1:0];
        end
      end
    end
  end

  // Working datapath registers
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (accept) begin
      err  <= err_next;
      diff <= DIFF_W'(err_next) - DIFF_W'(last_error);
    end
    if (div_start) deriv_neg <= diff[DIFF_W-1];
    case (state)
      S_ADD_P: sum <= SUM_W'(prod);
      S_ADD_I: sum <= sum + SUM_W'(prod);
      S_ADD_D: sum <= sum + SUM_W'(prod);
      default: ;
    endcase
    if (load_drive) drive <= clamped[DATA_WIDTH-1:0];
  end

  // Output register handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_drive) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

@@ design/pidc_divider.sv @@
// ----------------------------------------------------------------------------
// pidc_divider
// Restoring unsigned divider, one quotient bit per cycle. Divides a
// magnitude by the sample period; the quotient is truncated.
// ----------------------------------------------------------------------------
module pidc_divider
  import pidc_pkg::*;
#(
  parameter int DIVIDEND_W = DATA_WIDTH_DEF + 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [PERIOD_W-1:0]   divisor,
  output logic [DIVIDEND_W-1:0] quotient,
  output logic                  busy
);

  localparam int CNT_W = $clog2(DIVIDEND_W);

  logic [DIVIDEND_W-1:0] quo;
  logic [PERIOD_W-1:0]   rem;
  logic [PERIOD_W-1:0]   dvs;
  logic [CNT_W-1:0]      cnt;
  logic [PERIOD_W:0]     shifted;
  logic [PERIOD_W:0]     diff;
  logic                  fits;

  // Trial subtraction of the divisor from the shifted partial remainder
  always_comb begin
    shifted = {rem, quo[DIVIDEND_W-1]};
    fits    = (shifted >= {1'b0, dvs});
    diff    = shifted - {1'b0, dvs};
  end

  // Control: busy while the quotient bits are shifted in, counted down by cnt
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(DIVIDEND_W - 1);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  // Datapath: quotient bits shift in where the dividend shifts out
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[DIVIDEND_W-2:0], fits};
      rem <= fits ? diff[PERIOD_W-1:0] : shifted[PERIOD_W-1:0];
    end
  end

  assign quotient = quo;

endmodule

@@ dv/pid_controller_clamped_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pid_controller_clamped_core_tb
// Self-checking bench for the clamped PID controller core. Each accepted
// sample runs through a local copy of the controller arithmetic, which
// predicts the drive value. Returned drive transactions are checked in
// order. A directed part covers field extremes, a zero period, inverted
// output bounds, a zero integral limit and an unused register index. Random
// phases follow, with fresh gains and bounds and varied handshake pressure.
// ----------------------------------------------------------------------------
module pid_controller_clamped_core_tb;
  import pidc_pkg::*;

  localparam int W = DATA_WIDTH_DEF;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = 40;      // settle time before the final check
  localparam int ITEMS_PER_SEGMENT = 150;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  // DUT connections; the bench-driven inputs are set from time zero
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic signed [W-1:0]   target = '0;
  logic signed [W-1:0]   measured = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic signed [W-1:0]   drive;

  // Controller shadow: registers and loop state
  logic [PERIOD_W-1:0]      exp_period    = PERIOD_RST;
  logic signed [COEF_W-1:0] exp_out_max   = OUT_MAX_RST;
  logic signed [COEF_W-1:0] exp_out_min   = OUT_MIN_RST;
  logic signed [COEF_W-1:0] exp_kp        = '0;
  logic signed [COEF_W-1:0] exp_ki        = '0;
  logic signed [COEF_W-1:0] exp_kd        = '0;
  logic [PERIOD_W-1:0]      exp_int_limit = LIMIT_RST;
  logic signed [W:0]        exp_prev_err  = '0;
  logic signed [ACC_W-1:0]  exp_integral  = '0;

  logic signed [W-1:0] drive_expected[$];
  logic signed [W-1:0] drive_head;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int fail_count     = 0;
  int items_sent     = 0;
  int results_seen   = 0;
  int reg_writes     = 0;
  int cycle_count    = 0;

  // Sample state for steady-input runs
  int                  hold_left = 0;
  logic signed [W-1:0] hold_t = '0;
  logic signed [W-1:0] hold_m = '0;

  pid_controller_clamped_core #(.DATA_WIDTH(W)) uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .target    (target),
    .measured  (measured),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .drive     (drive)
  );

  // 10 ns clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Drive for one sample; advances the shadow integral and previous error
  function automatic logic signed [W-1:0] predict_drive(logic signed [W-1:0] t,
                                                        logic signed [W-1:0] m);
    longint err, per, divisor, lim, integ, deriv, sum;
    err = longint'(t) - longint'(m);
    per = longint'(exp_period);
    divisor = (per == 0) ? 1 : per;
    lim = longint'(exp_int_limit);

    integ = longint'(exp_integral) + err * per;
    if (integ > lim) integ = lim;
    else if (integ < -lim) integ = -lim;
    exp_integral = integ[ACC_W-1:0];

    // signed division truncates toward zero
    deriv = (err - longint'(exp_prev_err)) / divisor;

    sum = longint'(exp_kp) * err + longint'(exp_ki) * integ + longint'(exp_kd) * deriv;
    // upper bound is tested first, so inverted bounds favour output_max
    if (sum > longint'(exp_out_max)) sum = longint'(exp_out_max);
    else if (sum < longint'(exp_out_min)) sum = longint'(exp_out_min);

    exp_prev_err = err[W:0];
    return sum[W-1:0];
  endfunction

  // Register write; only issued while the core is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (cfg_reg_t'(idx))
      REG_SAMPLE_PERIOD:  exp_period = val[PERIOD_W-1:0];
      REG_OUTPUT_MAX:     exp_out_max = val;
      REG_OUTPUT_MIN:     exp_out_min = val;
      REG_GAIN_P:         exp_kp = val;
      REG_GAIN_I:         exp_ki = val;
      REG_GAIN_D:         exp_kd = val;
      REG_INTEGRAL_LIMIT: exp_int_limit = val[PERIOD_W-1:0];
      default: ;
    endcase
    reg_writes++;
    @(posedge clk);
  endtask

  // One input transaction, with an optional random gap in front
  task automatic send_sample(input logic signed [W-1:0] t, input logic signed [W-1:0] m);
    int gap;
    gap = 0;
    while (gap < 24 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    target <= t;
    measured <= m;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    drive_expected.push_back(predict_drive(t, m));
    items_sent++;
  endtask

  // Stop sending and wait for every outstanding drive value
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (drive_expected.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_gain();
    int r;
    r = $urandom_range(9);
    if (r < 6) return 16'($urandom_range(256) - 128);
    if (r < 8) return 16'($urandom);
    return (r == 8) ? 16'h7FFF : 16'h8000;
  endfunction

  // Fresh register set, extremes included
  task automatic random_config();
    int r;
    logic [CFG_DATA_W-1:0] hi, lo, v;
    r = $urandom_range(9);
    case (r)
      0:       v = '0;
      1:       v = 16'd1;
      2:       v = 16'hFFFF;                    // bit 15 is dropped
      7, 8, 9: v = 16'($urandom);
      default: v = 16'($urandom_range(8, 1));
    endcase
    write_reg(REG_SAMPLE_PERIOD, v);

    r = $urandom_range(9);
    if (r == 0) v = '0;
    else if (r == 1) v = 16'hFFFF;
    else if (r < 6) v = 16'($urandom_range(2000, 1));
    else v = 16'($urandom);
    write_reg(REG_INTEGRAL_LIMIT, v);

    r = $urandom_range(9);
    if (r < 3) begin
      hi = 16'h7FFF;
      lo = 16'h8000;
    end else if (r < 6) begin
      hi = 16'($urandom_range(20000));
      lo = 16'(-int'($urandom_range(20000)));
    end else if (r < 8) begin
      hi = 16'($urandom);
      lo = 16'($urandom);
    end else begin
      // inverted bounds
      v = 16'($urandom_range(20000, 1));
      hi = 16'(-int'(v));
      lo = v;
    end
    write_reg(REG_OUTPUT_MAX, hi);
    write_reg(REG_OUTPUT_MIN, lo);
    write_reg(REG_GAIN_P, pick_gain());
    write_reg(REG_GAIN_I, pick_gain());
    write_reg(REG_GAIN_D, pick_gain());
  endtask

  // Random sample: tracking errors, noise, extremes and steady runs
  task automatic next_sample(output logic signed [W-1:0] t, output logic signed [W-1:0] m);
    int r, sum;
    logic signed [W-1:0] corner[4];
    corner = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF};
    if (hold_left > 0) begin
      hold_left--;
      t = hold_t;
      m = hold_m;
      return;
    end
    r = $urandom_range(9);
    if (r < 4 || r == 9) begin
      t = 16'($urandom);
      sum = int'(t) + int'($urandom_range(64)) - 32;
      if (sum > 32767) sum = 32767;
      if (sum < -32768) sum = -32768;
      m = 16'(sum);
      if (r == 9) begin
        hold_left = $urandom_range(12, 2);
        hold_t = t;
        hold_m = m;
      end
    end else if (r < 8) begin
      t = 16'($urandom);
      m = 16'($urandom);
    end else begin
      t = corner[$urandom_range(3)];
      m = corner[$urandom_range(3)];
    end
  endtask

  // Reset registers: all gains zero, so every drive is zero
  task automatic test_reset_defaults();
    send_sample(16'sh7FFF, 16'sh8000);
    send_sample(16'sh8000, 16'sh7FFF);
    send_sample(16'sh0000, 16'sh0000);
    wait_drained();
  endtask

  // Largest errors and gains, output pinned at both bounds
  task automatic test_extremes();
    write_reg(REG_GAIN_P, 16'd1);
    send_sample(16'sh7FFF, 16'sh8000);
    send_sample(16'sh8000, 16'sh7FFF);
    send_sample(16'sh0001, 16'sh0000);
    wait_drained();
    write_reg(REG_GAIN_P, 16'h8000);
    write_reg(REG_GAIN_I, 16'h7FFF);
    write_reg(REG_GAIN_D, 16'h7FFF);
    send_sample(16'sh7FFF, 16'sh8000);
    send_sample(16'sh8000, 16'sh7FFF);
    send_sample(16'sh0000, 16'shFFFF);
    wait_drained();
  endtask

  // Zero period: integral frozen, derivative divided by one
  task automatic test_zero_period();
    write_reg(REG_SAMPLE_PERIOD, 16'd0);
    write_reg(REG_GAIN_P, 16'd0);
    write_reg(REG_GAIN_I, 16'd1);
    write_reg(REG_GAIN_D, 16'd1);
    send_sample(16'sd1000, 16'sd0);
    send_sample(16'sd0, 16'sd1000);
    send_sample(16'sd7, 16'sd7);
    wait_drained();
  endtask

  // Output bounds swapped: the upper clamp wins
  task automatic test_inverted_bounds();
    write_reg(REG_SAMPLE_PERIOD, 16'd3);
    write_reg(REG_OUTPUT_MAX, 16'hFF9C);     // -100
    write_reg(REG_OUTPUT_MIN, 16'd100);
    write_reg(REG_GAIN_P, 16'd1);
    write_reg(REG_GAIN_I, 16'd0);
    write_reg(REG_GAIN_D, 16'd0);
    send_sample(16'sd0, 16'sd0);
    send_sample(-16'sd1000, 16'sd0);
    send_sample(16'sd50, 16'sd0);
    wait_drained();
  endtask

  // Zero integral limit holds the accumulator at zero
  task automatic test_zero_limit();
    write_reg(REG_OUTPUT_MAX, 16'h7FFF);
    write_reg(REG_OUTPUT_MIN, 16'h8000);
    write_reg(REG_INTEGRAL_LIMIT, 16'd0);
    write_reg(REG_GAIN_I, 16'd1000);
    write_reg(REG_GAIN_D, 16'd2);
    send_sample(16'sd5000, 16'sd0);
    send_sample(16'sd5000, 16'sd0);
    send_sample(-16'sd5000, 16'sd0);
    wait_drained();
  endtask

  // A write to the unused index must not disturb anything
  task automatic test_unused_register();
    write_reg(REG_UNUSED, 16'hFFFF);
    send_sample(16'sd1234, -16'sd4321);
    send_sample(-16'sd77, 16'sd77);
    wait_drained();
  endtask

  // Random stream under one handshake pressure setting
  task automatic test_random_phase(input int send_pct, input int stall_pct);
    logic signed [W-1:0] t, m;
    send_idle_pct = send_pct;
    recv_stall_pct = stall_pct;
    for (int seg = 0; seg < 3; seg++) begin
      wait_drained();
      random_config();
      for (int i = 0; i < ITEMS_PER_SEGMENT; i++) begin
        // mid-segment hold-off until the core has emptied
        if (seg == 1 && i == ITEMS_PER_SEGMENT / 2) wait_drained();
        next_sample(t, m);
        send_sample(t, m);
      end
    end
    wait_drained();
  endtask

  // Result checker and receiver back-pressure
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && out_valid && out_ready) begin
      if (drive_expected.size() == 0) begin
        $error("drive: unexpected transaction, expected none, actual %0d", drive);
        fail_count++;
      end else begin
        drive_head = drive_expected.pop_front();
        results_seen++;
        if (drive !== drive_head) begin
          $error("drive mismatch: expected %0d, actual %0d", drive_head, drive);
          fail_count++;
        end
      end
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("CHECK FAILED");
    $finish;
  end

  // Test sequence
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_extremes();
    test_zero_period();
    test_inverted_bounds();
    test_zero_limit();
    test_unused_register();

    test_random_phase(0, 0);
    test_random_phase(46, 0);
    test_random_phase(0, 46);
    test_random_phase(29, 29);

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (drive_expected.size() != 0) begin
      $error("drive: %0d expected transactions never arrived", drive_expected.size());
      fail_count++;
    end

    $display("Summary: %0d samples sent, %0d drive values checked, %0d register writes",
             items_sent, results_seen, reg_writes);
    $display("Summary: directed corners, then four back-pressure phases, %0d errors",
             fail_count);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
